// File: src/rrs_pkg.sv
// Shared constants, types and helpers for the round-robin schedule core.
package rrs_pkg;

    localparam int MAX_PROCS = 32;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 22;
    localparam int VAL_W     = 16;
    localparam int LIDX_W    = 6;

    // One loaded process: sort key and load position
    typedef struct packed {
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] burst;
        logic [IDX_W-1:0] order;
    } t_rec;

    // Ring pointer step with wrap at the store depth
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
        if (v == IDX_W'(MAX_PROCS - 1)) begin
            return '0;
        end
        return v + 1'b1;
    endfunction

endpackage

// File: src/round_robin_schedule_sim_core.sv
// Top level: process loader, round-robin scheduler sequencer and report unit.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one process item: arrival time,
//   burst time and a last mark. Items are kept sorted by arrival (ties by
//   shorter burst) with an insertion pass through the record memory, one
//   entry moved per read and compare step; a new item is taken only
//   once the insertion of the previous one is done.
//   The item marked last, or the one that fills the store of MAX_PROCS
//   entries, starts the schedule run. The run sequencer steps through the
//   record, remaining-time, finish and ready-ring memories; each dispatch
//   reads the ring head, then its remaining time, runs it and admits
//   arrivals one at a time over the one read port of the record memory.
//   Afterwards one report item per process leaves on the output channel
//   (o_valid / i_ready) in sorted order, each after the one before is taken;
//   the final one carries o_last_result. A stall simply holds the report.
//   No input is taken from the last mark until the final report is taken.
//   i_cfg_wr_en / i_cfg_wr_data load the time quantum (zero means 65536).
//   Reset (synchronous, active low) empties the store and sets quantum 4;
//   memories need no clearing.
module round_robin_schedule_sim_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [15:0]                 i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [15:0]                 i_arrival_time,
    input  logic [15:0]                 i_burst_time,
    input  logic                        i_last_process,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [5:0]                  o_load_index,
    output logic [15:0]                 o_arrival_echo,
    output logic [15:0]                 o_burst_echo,
    output logic [21:0]                 o_finish_time,
    output logic [21:0]                 o_turnaround_time,
    output logic [21:0]                 o_waiting_time,
    output logic                        o_last_result
);
    import rrs_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_INS_RD, S_INS_CK, S_MAIN, S_JUMP, S_ADM_RD, S_ADM_CK,
        S_DSP_RD, S_DSP_RUN, S_RETIRE, S_OUT_RD, S_OUT_LD, S_OUT_WT
    } t_state;

    t_state              r_state;
    logic [VAL_W-1:0]    r_quantum;
    logic [CNT_W-1:0]    r_count, r_pos, r_na, r_pend, r_done, r_k;
    logic [IDX_W-1:0]    r_head, r_tail, r_p;
    logic [TIME_W-1:0]   r_tick;
    logic                r_remz, r_after, r_last;
    logic [VAL_W-1:0]    r_arr, r_bur;
    logic                r_ovalid;
    t_rec                r_orec;
    logic [TIME_W-1:0]   r_ofin, r_otat, r_owt;
    logic                r_olast;

    // memory ports
    logic                rec_we, rem_we, fin_we, ring_we;
    logic [IDX_W-1:0]    rec_waddr, rec_raddr, rem_waddr, rem_raddr;
    logic [IDX_W-1:0]    fin_waddr, ring_waddr, ring_wdata, ring_rdata;
    t_rec                rec_wdata, rec_rdata, new_rec;
    logic [VAL_W-1:0]    rem_wdata, rem_rdata;
    logic [TIME_W-1:0]   fin_wdata, fin_rdata;

    // helpers
    logic [VAL_W:0]      quant, run;
    logic [VAL_W-1:0]    rem_new;
    logic                shift_up, admit_ok;
    logic [CNT_W-1:0]    n_count;
    logic [TIME_W-1:0]   tat;

    assign quant    = (r_quantum == '0) ? (VAL_W+1)'(1 << VAL_W) : {1'b0, r_quantum};
    assign run      = ({1'b0, rem_rdata} < quant) ? {1'b0, rem_rdata} : quant;
    assign rem_new  = rem_rdata - run[VAL_W-1:0];
    assign new_rec  = '{arrival: r_arr, burst: r_bur, order: r_count[IDX_W-1:0]};
    assign shift_up = (rec_rdata.arrival > r_arr) ||
                      ((rec_rdata.arrival == r_arr) && (rec_rdata.burst > r_bur));
    assign admit_ok = (TIME_W'(rec_rdata.arrival) <= r_tick);
    assign n_count  = r_count + 1'b1;
    assign tat      = fin_rdata - TIME_W'(rec_rdata.arrival);

    // memory port steering
    always_comb begin
        rec_we     = 1'b0;
        rec_waddr  = r_pos[IDX_W-1:0];
        rec_wdata  = new_rec;
        rec_raddr  = r_na[IDX_W-1:0];
        rem_we     = 1'b0;
        rem_waddr  = r_na[IDX_W-1:0];
        rem_wdata  = rec_rdata.burst;
        rem_raddr  = ring_rdata;
        fin_we     = 1'b0;
        fin_waddr  = r_p;
        fin_wdata  = r_tick;
        ring_we    = 1'b0;
        ring_waddr = r_tail;
        ring_wdata = r_na[IDX_W-1:0];
        case (r_state)
            S_INS_RD: begin
                if (r_pos == '0) begin
                    rec_we = 1'b1;
                end
                rec_raddr = IDX_W'(r_pos - 1'b1);
            end
            S_INS_CK: begin
                rec_we    = 1'b1;
                rec_wdata = shift_up ? rec_rdata : new_rec;
            end
            S_ADM_CK: begin
                if (r_na < r_count && admit_ok) begin
                    ring_we = 1'b1;
                    rem_we  = 1'b1;
                end
            end
            S_DSP_RUN: begin
                rem_we    = 1'b1;
                rem_waddr = r_p;
                rem_wdata = rem_new;
            end
            S_RETIRE: begin
                fin_we     = r_remz;
                ring_we    = !r_remz;
                ring_wdata = r_p;
            end
            S_OUT_RD, S_OUT_LD, S_OUT_WT: begin
                rec_raddr = r_k[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    rrs_ram #(.WIDTH($bits(t_rec)), .DEPTH(MAX_PROCS)) u_rec_mem (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_waddr), .i_wdata(rec_wdata),
        .i_raddr(rec_raddr), .o_rdata(rec_rdata)
    );
    rrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_PROCS)) u_rem_mem (
        .i_clk(i_clk), .i_we(rem_we), .i_waddr(rem_waddr), .i_wdata(rem_wdata),
        .i_raddr(rem_raddr), .o_rdata(rem_rdata)
    );
    rrs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_fin_mem (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_raddr(r_k[IDX_W-1:0]), .o_rdata(fin_rdata)
    );
    rrs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_ring_mem (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(ring_waddr), .i_wdata(ring_wdata),
        .i_raddr(r_head), .o_rdata(ring_rdata)
    );

    // quantum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= VAL_W'(4);
        end else if (i_cfg_wr_en) begin
            r_quantum <= i_cfg_wr_data;
        end
    end

    // sequencer and report registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_pos    <= '0;
            r_na     <= '0;
            r_pend   <= '0;
            r_done   <= '0;
            r_k      <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_p      <= '0;
            r_tick   <= '0;
            r_remz   <= 1'b0;
            r_after  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                // take one item
                S_LOAD: begin
                    if (i_valid) begin
                        r_arr   <= i_arrival_time;
                        r_bur   <= i_burst_time;
                        r_last  <= i_last_process;
                        r_pos   <= r_count;
                        r_state <= S_INS_RD;
                    end
                end
                // insertion: read the entry below the hole
                S_INS_RD: begin
                    if (r_pos == '0) begin
                        r_count <= n_count;
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_na    <= '0;
                        r_pend  <= '0;
                        r_done  <= '0;
                        r_state <= (r_last || n_count == CNT_W'(MAX_PROCS)) ? S_MAIN : S_LOAD;
                    end else begin
                        r_state <= S_INS_CK;
                    end
                end
                S_INS_CK: begin
                    if (shift_up) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= n_count;
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_na    <= '0;
                        r_pend  <= '0;
                        r_done  <= '0;
                        r_state <= (r_last || n_count == CNT_W'(MAX_PROCS)) ? S_MAIN : S_LOAD;
                    end
                end
                // schedule loop head
                S_MAIN: begin
                    r_k <= '0;
                    if (r_done == r_count) begin
                        r_state <= S_OUT_RD;
                    end else if (r_pend == '0) begin
                        r_state <= (r_na >= r_count) ? S_OUT_RD : S_JUMP;
                    end else begin
                        r_head  <= idx_inc(r_head);
                        r_state <= S_DSP_RD;
                    end
                end
                // idle gap: time jumps to the next arrival
                S_JUMP: begin
                    r_tick  <= TIME_W'(rec_rdata.arrival);
                    r_after <= 1'b0;
                    r_state <= S_ADM_RD;
                end
                S_ADM_RD: begin
                    if (r_na < r_count) begin
                        r_state <= S_ADM_CK;
                    end else begin
                        r_state <= r_after ? S_RETIRE : S_MAIN;
                    end
                end
                S_ADM_CK: begin
                    if (admit_ok) begin
                        r_tail  <= idx_inc(r_tail);
                        r_pend  <= r_pend + 1'b1;
                        r_na    <= r_na + 1'b1;
                        r_state <= S_ADM_RD;
                    end else begin
                        r_state <= r_after ? S_RETIRE : S_MAIN;
                    end
                end
                // dispatch: ring head gives the process, fetch its remaining time
                S_DSP_RD: begin
                    r_p     <= ring_rdata;
                    r_state <= S_DSP_RUN;
                end
                S_DSP_RUN: begin
                    r_tick  <= r_tick + TIME_W'(run);
                    r_remz  <= (rem_new == '0);
                    r_after <= 1'b1;
                    r_state <= S_ADM_RD;
                end
                // finish or re-queue after arrivals were admitted
                S_RETIRE: begin
                    if (r_remz) begin
                        r_pend <= r_pend - 1'b1;
                        r_done <= r_done + 1'b1;
                    end else begin
                        r_tail <= idx_inc(r_tail);
                    end
                    r_state <= S_MAIN;
                end
                // reports
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_orec   <= rec_rdata;
                    r_ofin   <= fin_rdata;
                    r_otat   <= tat;
                    r_owt    <= tat - TIME_W'(rec_rdata.burst);
                    r_olast  <= (r_k + 1'b1 == r_count);
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT_WT;
                end
                S_OUT_WT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_k      <= r_k + 1'b1;
                        if (r_olast) begin
                            r_count <= '0;
                            r_na    <= '0;
                            r_pend  <= '0;
                            r_done  <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_ready           = (r_state == S_LOAD);
    assign o_valid           = r_ovalid;
    assign o_load_index      = LIDX_W'(r_orec.order);
    assign o_arrival_echo    = r_orec.arrival;
    assign o_burst_echo      = r_orec.burst;
    assign o_finish_time     = r_ofin;
    assign o_turnaround_time = r_otat;
    assign o_waiting_time    = r_owt;
    assign o_last_result     = r_olast;

    // loader and reporter never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output both open");

    // ready count never exceeds the loaded count
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= r_count) else $error("pending count out of range");

    // completions never exceed the loaded count
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_count) else $error("done count out of range");

    // final report empties the store
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_result) |=> (r_count == '0 && o_ready))
        else $error("store not emptied after run");

endmodule

// File: src/rrs_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the round-robin schedule core: directed and random batches.
`timescale 1ns / 1ps

module testbench;
    import rrs_pkg::*;

    // One process report as the core should emit it
    typedef struct {
        logic [5:0]  load_index;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [21:0] finish;
        logic [21:0] turnaround;
        logic [21:0] waiting;
        logic        last;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_arrival_time = '0;
    logic [15:0] i_burst_time = 16'd1;
    logic        i_last_process = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [5:0]  o_load_index;
    logic [15:0] o_arrival_echo;
    logic [15:0] o_burst_echo;
    logic [21:0] o_finish_time;
    logic [21:0] o_turnaround_time;
    logic [21:0] o_waiting_time;
    logic        o_last_result;

    round_robin_schedule_sim_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_last_process    (i_last_process),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_load_index      (o_load_index),
        .o_arrival_echo    (o_arrival_echo),
        .o_burst_echo      (o_burst_echo),
        .o_finish_time     (o_finish_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_last_result     (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    // Scheduler shadow state
    logic [15:0] sched_quantum = 16'd4;
    logic [15:0] batch_arr [MAX_PROCS];
    logic [15:0] batch_bur [MAX_PROCS];
    int          batch_ord [MAX_PROCS];
    int          batch_cnt = 0;
    int unsigned sim_tick;
    int          sim_next;
    int          ready_q [$];
    t_report     pending_reports [$];

    int items_sent = 0;
    int reports_seen = 0;
    int batches_run = 0;
    int errors = 0;
    int burst_left = 0;

    // Admit every arrival reached by the current tick
    function automatic void admit_arrivals();
        while (sim_next < batch_cnt && batch_arr[sim_next] <= sim_tick) begin
            ready_q.push_back(sim_next);
            sim_next++;
        end
    endfunction

    // Round-robin schedule of the loaded batch, queueing one report per process
    function automatic void schedule_batch();
        int unsigned rem [MAX_PROCS];
        int unsigned fin [MAX_PROCS];
        int unsigned q;
        int unsigned run;
        int done;
        int p;
        t_report r;
        for (int k = 0; k < batch_cnt; k++) rem[k] = batch_bur[k];
        q = (sched_quantum == 0) ? 65536 : sched_quantum;
        ready_q.delete();
        sim_next = 0;
        done = 0;
        sim_tick = batch_arr[0];
        admit_arrivals();
        while (done < batch_cnt) begin
            if (ready_q.size() == 0) begin
                // idle gap: jump to the next arrival
                sim_tick = batch_arr[sim_next];
                admit_arrivals();
            end else begin
                p = ready_q.pop_front();
                run = (rem[p] < q) ? rem[p] : q;
                sim_tick += run;
                rem[p] -= run;
                admit_arrivals();
                if (rem[p] == 0) begin
                    fin[p] = sim_tick;
                    done++;
                end else begin
                    ready_q.push_back(p);
                end
            end
        end
        for (int k = 0; k < batch_cnt; k++) begin
            r.load_index = batch_ord[k][5:0];
            r.arrival    = batch_arr[k];
            r.burst      = batch_bur[k];
            r.finish     = fin[k][21:0];
            r.turnaround = 22'(fin[k] - batch_arr[k]);
            r.waiting    = 22'(fin[k] - batch_arr[k] - batch_bur[k]);
            r.last       = (k == batch_cnt - 1);
            pending_reports.push_back(r);
        end
        batches_run++;
        batch_cnt = 0;
    endfunction

    // Sorted insert of one accepted process; runs the batch when it closes
    function automatic void load_process(logic [15:0] arr, logic [15:0] bur, logic last);
        int pos;
        pos = batch_cnt;
        while (pos > 0 && (batch_arr[pos-1] > arr ||
                           (batch_arr[pos-1] == arr && batch_bur[pos-1] > bur))) begin
            batch_arr[pos] = batch_arr[pos-1];
            batch_bur[pos] = batch_bur[pos-1];
            batch_ord[pos] = batch_ord[pos-1];
            pos--;
        end
        batch_arr[pos] = arr;
        batch_bur[pos] = bur;
        batch_ord[pos] = batch_cnt;
        batch_cnt++;
        if (last || batch_cnt == MAX_PROCS) schedule_batch();
    endfunction

    // Send one item, in bursts separated by random gaps
    task automatic send_item(input logic [15:0] arr, input logic [15:0] bur, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_valid        <= 1'b1;
        i_arrival_time <= arr;
        i_burst_time   <= bur;
        i_last_process <= last;
        do @(posedge i_clk); while (!o_ready);
        load_process(arr, bur, last);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Wait for every report and let the core settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_quantum(input logic [15:0] q);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= q;
        sched_quantum = q;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Receiver stall pattern: always ready, random, or mostly stalled
    int stall_mode = 0;
    int stall_span = 0;
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(8, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Report checker
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid && i_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected report, load index %0d", o_load_index);
            end else begin
                want = pending_reports.pop_front();
                if (o_load_index !== want.load_index || o_arrival_echo !== want.arrival ||
                    o_burst_echo !== want.burst || o_finish_time !== want.finish ||
                    o_turnaround_time !== want.turnaround ||
                    o_waiting_time !== want.waiting || o_last_result !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp idx %0d arr %0d bur %0d fin %0d tat %0d wt %0d last %0d",
                                 want.load_index, want.arrival, want.burst, want.finish,
                                 want.turnaround, want.waiting, want.last);
                        $display("         got idx %0d arr %0d bur %0d fin %0d tat %0d wt %0d last %0d",
                                 o_load_index, o_arrival_echo, o_burst_echo, o_finish_time,
                                 o_turnaround_time, o_waiting_time, o_last_result);
                    end
                end
            end
        end
    end

    // Default quantum: single process, ties, idle gap
    task automatic test_default_quantum();
        send_item(16'd0, 16'd1, 1'b1);
        send_item(16'd5, 16'd3, 1'b0);
        send_item(16'd5, 16'd2, 1'b0);
        send_item(16'd2, 16'd10, 1'b0);
        send_item(16'd40, 16'd4, 1'b1);
        send_item(16'd9, 16'd9, 1'b0);
        send_item(16'd9, 16'd9, 1'b1);
    endtask

    // Field extremes with quanta 65535, 1 and 3
    task automatic test_extremes();
        set_quantum(16'hFFFF);
        send_item(16'hFFFF, 16'hFFFF, 1'b0);
        send_item(16'h0000, 16'hFFFF, 1'b0);
        send_item(16'h0000, 16'h0001, 1'b0);
        send_item(16'hAAAA, 16'h5555, 1'b1);
        set_quantum(16'd1);
        send_item(16'd3, 16'd6, 1'b0);
        send_item(16'd0, 16'd5, 1'b0);
        send_item(16'd1, 16'd1, 1'b1);
        set_quantum(16'd3);
        send_item(16'h5555, 16'd7, 1'b0);
        send_item(16'h5555, 16'd2, 1'b1);
    endtask

    // Burst length bounded so the schedule stays short at small quanta
    function automatic logic [15:0] pick_burst();
        int unsigned cap;
        cap = sched_quantum * 8;
        if (cap > 65535) cap = 65535;
        if ($urandom_range(0, 4) == 0) cap = (cap < 16) ? cap : 16;
        return 16'($urandom_range(1, cap));
    endfunction

    // One batch with random content; size 0 means fill the store
    task automatic send_batch(input int size);
        int n;
        int span;
        n = (size == 0) ? MAX_PROCS : size;
        span = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            case (span)
                0: send_item(16'($urandom_range(0, 40)), pick_burst(), size != 0 && k == n - 1);
                1: send_item(16'($urandom_range(0, 600)), pick_burst(), size != 0 && k == n - 1);
                default: send_item(16'($urandom), pick_burst(), size != 0 && k == n - 1);
            endcase
        end
    endtask

    // Store filled without a last mark starts the run, then a new batch follows
    task automatic test_full_store();
        set_quantum(16'd2);
        send_batch(0);
        send_batch(3);
    endtask

    // Random batches over several quanta, with pauses until all reports are in
    task automatic test_random();
        logic [15:0] quanta [6];
        int ph;
        quanta = '{16'd1, 16'd7, 16'd300, 16'd4096, 16'hFFFF, 16'd4};
        ph = 0;
        while (items_sent < 410) begin
            if (ph % 4 == 0)
                set_quantum((ph / 4 < 6) ? quanta[ph / 4] : 16'($urandom_range(1, 65535)));
            else if (ph % 4 == 2)
                wait_drained();
            send_batch(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
            ph++;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_quantum();
        test_extremes();
        test_full_store();
        test_random();
        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("ran %0d process items in %0d batches, %0d reports checked",
                 items_sent, batches_run, reports_seen);
        $display("quanta from 1 to 65535, full-store batches, ties and idle gaps covered");
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d reports missing", errors, pending_reports.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    // Timeout
    initial begin
        #30_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
src/rrs_pkg.sv
src/rrs_ram.sv
src/round_robin_schedule_sim_core.sv
test/testbench.sv
